>>> hdl/idm_pkg.sv
// Shared types and constants for the IDM acceleration block.
package idm_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ACCEL     = 2'd0,
    CFG_COMFORT_DECEL = 2'd1,
    CFG_MIN_GAP       = 2'd2,
    CFG_TIME_HEADWAY  = 2'd3
  } cfg_idx_e_t;

  localparam logic [11:0] MAX_ACCEL_RST     = 12'd384;
  localparam logic [11:0] COMFORT_DECEL_RST = 12'd512;
  localparam logic [15:0] MIN_GAP_RST       = 16'd512;
  localparam logic [11:0] TIME_HEADWAY_RST  = 12'd384;

  // 0.5 m/s in Q8.8 and 0.2 m in Q16.8.
  localparam logic [15:0] V0_FLOOR  = 16'd128;
  localparam logic [22:0] GAP_FLOOR = 23'd51;

  typedef struct packed {
    logic [15:0]        own_speed;
    logic [15:0]        target_speed;
    logic               leader_present;
    logic signed [23:0] gap_to_leader;
    logic [15:0]        leader_velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] accel_out;
    logic               saturated;
  } out_item_t;

endpackage

>>> hdl/idm_car_following_acceleration.sv
// Top level of the pipelined Intelligent Driver Model acceleration block.
// One vehicle may be started in every clock cycle and busy is low at all times after reset;
// each result appears on out_item with out_valid high for one cycle, once its transfer has
// passed all stages, in the order of the inputs. The latency is set by the three restoring
// dividers (speed ratio, 25 stages; closing-speed term, 39 stages; gap ratio, 25 stages) and
// the 13-stage square root, each retiring one quotient or root bit per register stage.
// Configuration writes take effect at once and must only be made while no vehicle is in flight.
module idm_car_following_acceleration
  import idm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ST_D1_HI   = 25;
  localparam int ST_R2      = 26;
  localparam int ST_FREE    = 27;
  localparam int ST_SQ_LO   = 28;
  localparam int ST_SQ_HI   = 40;
  localparam int ST_D2_PREP = 41;
  localparam int ST_D2_LO   = 42;
  localparam int ST_D2_HI   = 80;
  localparam int ST_SUM     = 81;
  localparam int ST_OVF     = 82;
  localparam int ST_D3_LO   = 83;
  localparam int ST_D3_HI   = 107;
  localparam int ST_INTER   = 108;
  localparam int ST_DIFF    = 109;
  localparam int ST_MUL     = 110;
  localparam int NSTG       = 112;

  typedef struct packed {
    logic [15:0]        v;
    logic [15:0]        v0;
    logic               lp;
    logic [22:0]        gd;
    logic signed [16:0] dv;
    logic [31:0]        acc1;
    logic [24:0]        r;
    logic [25:0]        r2;
    logic signed [35:0] free;
    logic [23:0]        ab;
    logic signed [33:0] vdv;
    logic [12:0]        sq;
    logic [13:0]        dd;
    logic               neg;
    logic [39:0]        acc2;
    logic [38:0]        t2q;
    logic [27:0]        t1;
    logic [48:0]        acc3;
    logic               qovf;
    logic [24:0]        q;
    logic [32:0]        inter;
    logic signed [36:0] diff;
    logic signed [33:0] mres;
    logic signed [15:0] accel;
    logic               sat;
  } stage_t;

  logic [11:0] max_accel_r;
  logic [11:0] comfort_decel_r;
  logic [15:0] min_gap_r;
  logic [11:0] time_headway_r;
  logic        busy_r;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  stage_t      item_r   [NSTG];
  stage_t      item_nxt [NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_accel_r     <= MAX_ACCEL_RST;
      comfort_decel_r <= COMFORT_DECEL_RST;
      min_gap_r       <= MIN_GAP_RST;
      time_headway_r  <= TIME_HEADWAY_RST;
    end else if (cfg_we) begin
      case (cfg_idx_e_t'(cfg_index))
        CFG_MAX_ACCEL:     max_accel_r     <= cfg_wdata[11:0];
        CFG_COMFORT_DECEL: comfort_decel_r <= cfg_wdata[11:0];
        CFG_MIN_GAP:       min_gap_r       <= cfg_wdata;
        CFG_TIME_HEADWAY:  time_headway_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    vld_nxt = {vld_r[NSTG-2:0], start & ~busy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= vld_nxt;
    end
  end

  always_comb begin
    stage_t             p;
    int                 k;
    logic [40:0]        sh1;
    logic [12:0]        t;
    logic [25:0]        tt;
    logic [52:0]        sh2;
    logic [48:0]        sh3;
    logic [49:0]        rr;
    logic [33:0]        r2f;
    logic [51:0]        r4p;
    logic [33:0]        mag;
    logic [12:0]        sqf;
    logic signed [39:0] t2;
    logic signed [40:0] sum;
    logic [40:0]        sstar;
    logic [24:0]        qc;
    logic [49:0]        qq;
    logic signed [49:0] mp;
    for (int i = 0; i < NSTG; i++) begin
      k = 0;
      sh1 = '0; t = '0; tt = '0; sh2 = '0; sh3 = '0; rr = '0; r2f = '0; r4p = '0;
      mag = '0; sqf = '0; t2 = '0; sum = '0; sstar = '0; qc = '0; qq = '0; mp = '0;
      if (i == 0) begin
        p = '0;
        p.v  = in_item.own_speed;
        p.v0 = (in_item.target_speed < V0_FLOOR) ? V0_FLOOR : in_item.target_speed;
        p.lp = in_item.leader_present;
        p.gd = (in_item.gap_to_leader < $signed({1'b0, GAP_FLOOR})) ?
               GAP_FLOOR : in_item.gap_to_leader[22:0];
        p.dv = $signed({1'b0, in_item.own_speed}) - $signed({1'b0, in_item.leader_velocity});
        p.acc1 = {in_item.own_speed, 16'd0};
        p.r    = '0;
      end else begin
        p = item_r[i-1];
        if (i <= ST_D1_HI) begin
          // Speed ratio divider, one quotient bit per stage.
          k = ST_D1_HI - i;
          sh1 = {25'd0, p.v0} << k;
          if ({9'd0, p.acc1} >= sh1) begin
            p.acc1 = p.acc1 - sh1[31:0];
            p.r[k] = 1'b1;
          end
        end else if (i == ST_R2) begin
          rr = {25'd0, p.r} * {25'd0, p.r};
          r2f = rr[49:16];
          p.r2 = (r2f > 34'h2000000) ? 26'h2000000 : r2f[25:0];
          p.ab = {12'd0, max_accel_r} * {12'd0, comfort_decel_r};
        end else if (i == ST_FREE) begin
          r4p = {26'd0, p.r2} * {26'd0, p.r2};
          p.free = $signed(36'd65536) - $signed(r4p[51:16]);
          p.vdv = $signed({1'b0, p.v}) * p.dv;
          p.sq = '0;
        end else if (i >= ST_SQ_LO && i <= ST_SQ_HI) begin
          // Square root of a*b, one root bit per stage.
          k = ST_SQ_HI - i;
          t = p.sq | (13'd1 << k);
          tt = t * t;
          if (tt <= {2'd0, p.ab}) begin
            p.sq = t;
          end
        end else if (i == ST_D2_PREP) begin
          sqf = (p.sq == '0) ? 13'd1 : p.sq;
          p.dd = {sqf, 1'b0};
          p.neg = p.vdv[33];
          mag = p.neg ? 34'(-p.vdv) : 34'(p.vdv);
          p.acc2 = {mag[31:0], 8'd0};
          p.t2q = '0;
          p.t1 = {12'd0, p.v} * {16'd0, time_headway_r};
        end else if (i >= ST_D2_LO && i <= ST_D2_HI) begin
          // Closing-speed term: magnitude divided by 2*sqrt(a*b).
          k = ST_D2_HI - i;
          sh2 = {39'd0, p.dd} << k;
          if ({13'd0, p.acc2} >= sh2) begin
            p.acc2 = p.acc2 - sh2[39:0];
            p.t2q[k] = 1'b1;
          end
        end else if (i == ST_SUM) begin
          t2 = p.neg ? -$signed({1'b0, p.t2q}) : $signed({1'b0, p.t2q});
          sum = $signed({13'd0, p.t1}) + 41'(t2);
          if (sum < 0) begin
            sum = '0;
          end
          sstar = {17'd0, min_gap_r, 8'd0} + sum;
          p.acc3 = {sstar, 8'd0};
        end else if (i == ST_OVF) begin
          // A quotient of 2^25 or more is capped anyway, so the divider only needs 25 bits.
          p.qovf = p.acc3 >= {1'b0, p.gd, 25'd0};
          p.q = '0;
        end else if (i >= ST_D3_LO && i <= ST_D3_HI) begin
          k = ST_D3_HI - i;
          sh3 = {26'd0, p.gd} << k;
          if (p.acc3 >= sh3) begin
            p.acc3 = p.acc3 - sh3;
            p.q[k] = 1'b1;
          end
        end else if (i == ST_INTER) begin
          qc = (p.qovf || p.q > 25'h1000000) ? 25'h1000000 : p.q;
          qq = {25'd0, qc} * {25'd0, qc};
          p.inter = qq[48:16];
        end else if (i == ST_DIFF) begin
          p.diff = 37'(p.free) - (p.lp ? $signed({4'd0, p.inter}) : 37'sd0);
        end else if (i == ST_MUL) begin
          mp = $signed({1'b0, max_accel_r}) * p.diff;
          p.mres = mp[49:16];
        end else begin
          if (p.mres > 34'sd32767) begin
            p.accel = 16'sd32767;
            p.sat = 1'b1;
          end else if (p.mres < -34'sd32768) begin
            p.accel = -16'sd32768;
            p.sat = 1'b1;
          end else begin
            p.accel = p.mres[15:0];
            p.sat = 1'b0;
          end
        end
      end
      item_nxt[i] = p;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign busy                = busy_r;
  assign out_valid           = vld_r[NSTG-1];
  assign out_item.accel_out  = item_r[NSTG-1].accel;
  assign out_item.saturated  = item_r[NSTG-1].sat;

`ifndef SYNTHESIS
  // Every result stems from an input transfer that has passed through the whole pipeline.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, NSTG))
    else $error("result without a matching input transfer");

  // The free-road term never exceeds one, so only the negative limit can be reached.
  a_sat_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |-> out_item.accel_out == -16'sd32768)
    else $error("saturation flagged on a non-negative limit");

  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised after reset");
`endif

endmodule
